[hdl/bal_pkg.sv]
// Shared constants, field widths, command and status codes for the bounded array list.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`default_nettype none
package bal_pkg;

    localparam int CAPACITY_ENTRIES = 16;
    localparam int DATA_WIDTH       = 32;

    // Fixed widths of the command and result item fields
    localparam int CMD_W   = 3;
    localparam int POS_W   = 4;
    localparam int VIN_W   = 32;
    localparam int VOUT_W  = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    // Derived widths
    localparam int IDX_W = (CAPACITY_ENTRIES > 1) ? $clog2(CAPACITY_ENTRIES) : 1;
    localparam int CNT_W = $clog2(CAPACITY_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int VAL_W = (DATA_WIDTH < VIN_W) ? DATA_WIDTH : VIN_W;

    localparam logic [CMP_W-1:0]   CAP_CMP       = CMP_W'(CAPACITY_ENTRIES);
    localparam logic [COUNT_W-1:0] CAP_COUNT_OUT = COUNT_W'(CAPACITY_ENTRIES % 32);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIRST  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_LAST   = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_BADIDX = 2'd3;

    typedef logic [DATA_WIDTH-1:0] data_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] position;
        logic [VIN_W-1:0] value_in;
    } item_t;

    typedef struct packed {
        logic [VOUT_W-1:0]  value_out;
        logic [STAT_W-1:0]  status;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
    } res_t;

endpackage
`default_nettype wire

[hdl/bal_if.sv]
// Valid/ready channel interfaces for command items and result items.
// Depends on bal_pkg for field widths.
`default_nettype none
interface bal_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [bal_pkg::CMD_W-1:0]  cmd;
    logic [bal_pkg::POS_W-1:0]  position;
    logic [bal_pkg::VIN_W-1:0]  value_in;

    modport source (output valid, output cmd, output position, output value_in, input ready);
    modport sink   (input valid, input cmd, input position, input value_in, output ready);
endinterface

interface bal_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bal_pkg::VOUT_W-1:0]   value_out;
    logic [bal_pkg::STAT_W-1:0]   status;
    logic [bal_pkg::COUNT_W-1:0]  count;
    logic                         is_empty;

    modport source (output valid, output value_out, output status, output count,
                    output is_empty, input ready);
    modport sink   (input valid, input value_out, input status, input count,
                    input is_empty, output ready);
endinterface
`default_nettype wire

[hdl/bounded_array_list_unit.sv]
// Top level of the bounded array list: command channel, sequencer, result register.
// Depends on bal_pkg, bal_if (bal_cmd_if, bal_rsp_if) and bal_engine.
//
// A fixed-capacity ordered list of bal_pkg::CAPACITY_ENTRIES words kept in a
// single-port-write, registered-read memory plus an entry count. Each command
// item (append, remove at position, read at position, read first, read last)
// yields exactly one result item carrying the read value (zero unless a read
// succeeds), a status (ok, full, empty, invalid index), the count after the
// command and an empty flag. Unknown command codes leave the list untouched
// and report ok. One item is in work at a time; cmd_ch.ready is high only
// while the sequencer is idle. A remove walks the upper entries down one
// place at a time, each step a read at idx+1 followed by a write at idx
// through the one memory port pair, with one shared comparator deciding
// both the bound checks and the end of the walk. The result sits in an
// output register, so the next command is accepted while a finished result
// still waits for rsp_ch.ready. The memory needs no clearing after reset;
// only entries below the count are ever read.
`default_nettype none
module bounded_array_list_unit (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bal_cmd_if.sink    cmd_ch,
    bal_rsp_if.source  rsp_ch
);

    bal_pkg::item_t  item;
    bal_pkg::res_t   eng_res;
    bal_pkg::res_t   res_reg;
    logic            out_valid_reg;
    logic            eng_idle;
    logic            eng_done;
    logic            take;
    logic            start;

    assign item.cmd      = cmd_ch.cmd;
    assign item.position = cmd_ch.position;
    assign item.value_in = cmd_ch.value_in;

    assign cmd_ch.ready = eng_idle;
    assign start        = cmd_ch.valid && eng_idle;

    // Move a finished result into the output register once it is free
    assign take = eng_done && (!out_valid_reg || rsp_ch.ready);

    bal_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .idle  (eng_idle),
        .done  (eng_done),
        .take  (take),
        .res   (eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload register: load on take, hold otherwise
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= eng_res;
        end
    end

    assign rsp_ch.valid     = out_valid_reg;
    assign rsp_ch.value_out = res_reg.value_out;
    assign rsp_ch.status    = res_reg.status;
    assign rsp_ch.count     = res_reg.count;
    assign rsp_ch.is_empty  = res_reg.is_empty;

`ifndef SYNTHESIS
    // A failed command never returns read data
    a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.status != bal_pkg::ST_OK) |-> (res_reg.value_out == '0))
        else $error("failed command returned nonzero value_out");

    // An accepted item keeps the sequencer busy on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_ch.valid && cmd_ch.ready) |=> !cmd_ch.ready)
        else $error("command accepted while previous item in work");

    // A full status only reports a list at capacity
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.status == bal_pkg::ST_FULL)
            |-> (res_reg.count == bal_pkg::CAP_COUNT_OUT))
        else $error("full status with count below capacity");
`endif

endmodule
`default_nettype wire

[hdl/bal_engine.sv]
// Command sequencer with the entry memory and one shared magnitude comparator.
// Depends on bal_pkg.
`default_nettype none
module bal_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire bal_pkg::item_t item,
    output logic                idle,
    output logic                done,
    input  wire logic           take,
    output bal_pkg::res_t       res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WAIT,
        S_SHIFT,
        S_MOVE,
        S_DONE
    } state_t;

    state_t                            state_reg, state_next;
    logic [bal_pkg::CNT_W-1:0]         count_reg, count_next;
    logic [bal_pkg::CMP_W-1:0]         idx_reg, idx_next;
    bal_pkg::item_t                    item_reg, item_next;
    logic [bal_pkg::STAT_W-1:0]        status_reg, status_next;
    logic [bal_pkg::VOUT_W-1:0]        value_reg, value_next;

    // Entry memory: one write port, one registered read port
    bal_pkg::data_t                    mem [0:bal_pkg::CAPACITY_ENTRIES-1];
    bal_pkg::data_t                    rd_data_reg;
    logic                              we;
    logic [bal_pkg::IDX_W-1:0]         waddr;
    bal_pkg::data_t                    wdata;
    logic                              re;
    logic [bal_pkg::IDX_W-1:0]         raddr;

    // Shared comparator
    logic [bal_pkg::CMP_W-1:0]         cmp_a, cmp_b;
    logic                              cmp_lt;

    logic [bal_pkg::CMP_W-1:0]         pos_ext, count_ext, idx_inc, last_idx;
    logic                              list_empty;

    assign pos_ext    = bal_pkg::CMP_W'(item_reg.position);
    assign count_ext  = bal_pkg::CMP_W'(count_reg);
    assign idx_inc    = idx_reg + bal_pkg::CMP_W'(1);
    assign last_idx   = count_ext - bal_pkg::CMP_W'(1);
    assign list_empty = (count_reg == '0);

    always_comb
    begin
        if (state_reg == S_SHIFT)
        begin
            cmp_a = idx_inc;
            cmp_b = count_ext;
        end
        else if (item_reg.cmd == bal_pkg::CMD_APPEND)
        begin
            cmp_a = count_ext;
            cmp_b = bal_pkg::CAP_CMP;
        end
        else
        begin
            cmp_a = pos_ext;
            cmp_b = count_ext;
        end
    end

    assign cmp_lt = (cmp_a < cmp_b);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        item_next   = item_reg;
        status_next = status_reg;
        value_next  = value_reg;
        we          = 1'b0;
        waddr       = count_ext[bal_pkg::IDX_W-1:0];
        wdata       = bal_pkg::data_t'(item_reg.value_in[bal_pkg::VAL_W-1:0]);
        re          = 1'b0;
        raddr       = pos_ext[bal_pkg::IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next   = item;
                    status_next = bal_pkg::ST_OK;
                    value_next  = '0;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (item_reg.cmd)
                    bal_pkg::CMD_APPEND:
                    begin
                        if (!cmp_lt)
                        begin
                            status_next = bal_pkg::ST_FULL;
                        end
                        else
                        begin
                            we         = 1'b1;
                            count_next = count_reg + bal_pkg::CNT_W'(1);
                        end
                    end
                    bal_pkg::CMD_REMOVE:
                    begin
                        if (list_empty)
                        begin
                            status_next = bal_pkg::ST_EMPTY;
                        end
                        else if (!cmp_lt)
                        begin
                            status_next = bal_pkg::ST_BADIDX;
                        end
                        else
                        begin
                            idx_next   = pos_ext;
                            state_next = S_SHIFT;
                        end
                    end
                    bal_pkg::CMD_READ:
                    begin
                        if (!cmp_lt)
                        begin
                            status_next = bal_pkg::ST_BADIDX;
                        end
                        else
                        begin
                            re         = 1'b1;
                            state_next = S_WAIT;
                        end
                    end
                    bal_pkg::CMD_FIRST:
                    begin
                        if (list_empty)
                        begin
                            status_next = bal_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            re         = 1'b1;
                            raddr      = '0;
                            state_next = S_WAIT;
                        end
                    end
                    bal_pkg::CMD_LAST:
                    begin
                        if (list_empty)
                        begin
                            status_next = bal_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            re         = 1'b1;
                            raddr      = last_idx[bal_pkg::IDX_W-1:0];
                            state_next = S_WAIT;
                        end
                    end
                    default:
                    begin
                        status_next = bal_pkg::ST_OK;
                    end
                endcase
            end
            S_WAIT:
            begin
                value_next = bal_pkg::VOUT_W'(rd_data_reg[bal_pkg::VAL_W-1:0]);
                state_next = S_DONE;
            end
            S_SHIFT:
            begin
                // Fetch the next entry if one remains above idx, else close the gap
                if (cmp_lt)
                begin
                    re         = 1'b1;
                    raddr      = idx_inc[bal_pkg::IDX_W-1:0];
                    state_next = S_MOVE;
                end
                else
                begin
                    count_next = count_reg - bal_pkg::CNT_W'(1);
                    state_next = S_DONE;
                end
            end
            S_MOVE:
            begin
                we         = 1'b1;
                waddr      = idx_reg[bal_pkg::IDX_W-1:0];
                wdata      = rd_data_reg;
                idx_next   = idx_inc;
                state_next = S_SHIFT;
            end
            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            status_reg <= bal_pkg::ST_OK;
            value_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            status_reg <= status_next;
            value_reg  <= value_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign idle = (state_reg == S_IDLE);
    assign done = (state_reg == S_DONE);

    assign res.value_out = value_reg;
    assign res.status    = status_reg;
    assign res.count     = bal_pkg::COUNT_W'(count_reg);
    assign res.is_empty  = list_empty;

endmodule
`default_nettype wire
